>>> design/crc8fpr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fpr_pkg: shared types and constants for the crc-8 frame receiver
// Item structs, parse phases, result kinds and the crc-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fpr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  // reflected form of polynomial 0x31
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] CRC_INIT    = 8'h00;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_FUNC    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_OK      = 2'd1,
    K_BAD     = 2'd2,
    K_TIMEOUT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout_expired;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] func_code;
    logic [7:0] frame_length;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] computed_crc;
  } out_item_t;

  // one byte through the reflected crc-8, bit by bit
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/crc8fpr_parser.sv
// ----------------------------------------------------------------------------
// crc8fpr_parser: frame parse state and per-item decode
// Holds the parse phase, frame header fields, payload count and running crc,
// and works out the result for the item at its input.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fpr_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire crc8fpr_pkg::in_item_t item,
  input  wire logic                  advance,
  output crc8fpr_pkg::out_item_t     res,
  output logic                       has_res
);

  crc8fpr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] func_r, func_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;

  logic [7:0] crc_in;
  logic [7:0] crc_b;
  logic [7:0] cnt_inc;

  // function byte starts a fresh crc
  assign crc_in  = (phase_r == crc8fpr_pkg::PH_FUNC) ? crc8fpr_pkg::CRC_INIT : crc_r;
  assign crc_b   = crc8fpr_pkg::crc8_byte(crc_in, item.rx_byte);
  assign cnt_inc = cnt_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crc8fpr_pkg::PH_HUNT1;
      func_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      func_r  <= func_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    func_nxt         = func_r;
    len_nxt          = len_r;
    cnt_nxt          = cnt_r;
    crc_nxt          = crc_r;
    has_res          = 1'b0;
    res.kind         = crc8fpr_pkg::K_PAYLOAD;
    res.func_code    = func_r;
    res.frame_length = len_r;
    res.data_byte    = item.rx_byte;
    res.byte_index   = cnt_r;
    res.computed_crc = crc_r;

    if (item.timeout_expired) begin
      res.kind      = crc8fpr_pkg::K_TIMEOUT;
      res.data_byte = '0;
      // nothing in progress while hunting the first sync byte
      has_res       = (phase_r != crc8fpr_pkg::PH_HUNT1) &&
                      (phase_r <= crc8fpr_pkg::PH_CHECK);
      phase_nxt     = crc8fpr_pkg::PH_HUNT1;
      func_nxt      = '0;
      len_nxt       = '0;
      cnt_nxt       = '0;
      crc_nxt       = '0;
    end else begin
      case (phase_r)
        crc8fpr_pkg::PH_HUNT2: begin
          phase_nxt = (item.rx_byte == crc8fpr_pkg::SYNC_SECOND) ?
                      crc8fpr_pkg::PH_FUNC : crc8fpr_pkg::PH_HUNT1;
        end
        crc8fpr_pkg::PH_FUNC: begin
          func_nxt  = item.rx_byte;
          crc_nxt   = crc_b;
          phase_nxt = crc8fpr_pkg::PH_LEN;
        end
        crc8fpr_pkg::PH_LEN: begin
          len_nxt   = item.rx_byte;
          cnt_nxt   = '0;
          crc_nxt   = crc_b;
          phase_nxt = (item.rx_byte == 8'd0) ? crc8fpr_pkg::PH_CHECK : crc8fpr_pkg::PH_PAYLOAD;
        end
        crc8fpr_pkg::PH_PAYLOAD: begin
          crc_nxt          = crc_b;
          cnt_nxt          = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = crc8fpr_pkg::PH_CHECK;
          end
          has_res          = 1'b1;
          res.kind         = crc8fpr_pkg::K_PAYLOAD;
          res.computed_crc = crc_b;
        end
        crc8fpr_pkg::PH_CHECK: begin
          has_res   = 1'b1;
          res.kind  = (crc_r == item.rx_byte) ? crc8fpr_pkg::K_OK : crc8fpr_pkg::K_BAD;
          phase_nxt = crc8fpr_pkg::PH_HUNT1;
          func_nxt  = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          crc_nxt   = '0;
        end
        default: begin
          func_nxt  = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          crc_nxt   = '0;
          phase_nxt = (item.rx_byte == crc8fpr_pkg::SYNC_FIRST) ?
                      crc8fpr_pkg::PH_HUNT2 : crc8fpr_pkg::PH_HUNT1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/crc8_framed_packet_receiver_core.sv
// Sync/length/crc-8 frame receiver. Bytes enter one item per clock while in_stall is
// low and are parsed against frames of AA 55, function id, length, payload, crc-8
// (reflected 0x31, init 0). Each payload byte leaves as a kind 0 item; the checksum
// byte yields frame ok or checksum mismatch, and a timeout item aborts any frame in
// progress with a kind 3 item. Throughput is one item per clock when no stall holds
// the flow: an input register feeds the parse logic, which loads a result register.
// A stalled result holds back only items that would produce a result; sync, header
// and idle-hunt bytes keep flowing.
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_core: top level of the crc-8 frame receiver
// Input register, parser and result register with valid/stall handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_framed_packet_receiver_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire crc8fpr_pkg::in_item_t in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output crc8fpr_pkg::out_item_t     out_item
);

  logic                   a_valid_r, a_valid_nxt;
  crc8fpr_pkg::in_item_t  a_item_r;
  logic                   o_valid_r, o_valid_nxt;
  crc8fpr_pkg::out_item_t o_item_r;

  crc8fpr_pkg::out_item_t res;
  logic                   has_res;
  logic                   a_adv;
  logic                   a_load;
  logic                   o_load;

  crc8fpr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (a_item_r),
    .advance (a_adv),
    .res     (res),
    .has_res (has_res)
  );

  // an item with no result never waits on the output side
  assign a_adv    = a_valid_r && (!has_res || !o_valid_r || !out_stall);
  assign in_stall = a_valid_r && !a_adv;
  assign a_load   = in_valid && !in_stall;
  assign o_load   = a_adv && has_res;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (o_load) begin
      o_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item_r <= in_item;
    end
    if (o_load) begin
      o_item_r <= res;
    end
  end

  assign out_valid = o_valid_r;
  assign out_item  = o_item_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !a_valid_r && !o_valid_r)
    else $error("pipeline not empty after reset");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r && has_res && o_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    o_load |=> o_valid_r && (o_item_r == $past(res)))
    else $error("result not captured in output register");

  a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && out_stall |=> o_valid_r)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

>>> sim/crc8fpr_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8fpr_frame_checker: result checker for the crc-8 frame receiver
// Watches both channels and tracks the frame parse per accepted item. Each
// result is compared field by field with the oldest outstanding frame event.
// ----------------------------------------------------------------------------
module crc8fpr_frame_checker
  import crc8fpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        events_left
);

  phase_t     phase_q;
  logic [7:0] func_q;
  logic [7:0] len_q;
  logic [7:0] count_q;
  logic [7:0] crc_q;
  out_item_t  frame_events_q[$];

  initial begin
    mismatch_count = 0;
    events_left    = 0;
  end

  // lsb-first shift, feedback taken per data bit
  function automatic logic [7:0] crc_shift_in(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ din[i];
      r  = {1'b0, r[7:1]};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic out_item_t frame_event(input kind_t k, input logic [7:0] data,
                                            input logic [7:0] idx);
    out_item_t r;
    r.kind         = k;
    r.func_code    = func_q;
    r.frame_length = len_q;
    r.data_byte    = data;
    r.byte_index   = idx;
    r.computed_crc = crc_q;
    return r;
  endfunction

  function automatic void add_event(input out_item_t e);
    frame_events_q.insert(frame_events_q.size(), e);
  endfunction

  function automatic void clear_frame();
    phase_q = PH_HUNT1;
    func_q  = '0;
    len_q   = '0;
    count_q = '0;
    crc_q   = '0;
  endfunction

  function automatic void parse_rx_item(input in_item_t it);
    logic [7:0] b;
    logic [7:0] idx;
    b = it.rx_byte;
    if (it.timeout_expired) begin
      // nothing to abort while hunting the first sync byte
      if (phase_q != PH_HUNT1) begin
        add_event(frame_event(K_TIMEOUT, 8'h00, count_q));
      end
      clear_frame();
    end else begin
      case (phase_q)
        PH_HUNT2: begin
          phase_q = (b == SYNC_SECOND) ? PH_FUNC : PH_HUNT1;
        end
        PH_FUNC: begin
          func_q  = b;
          crc_q   = crc_shift_in(CRC_INIT, b);
          phase_q = PH_LEN;
        end
        PH_LEN: begin
          len_q   = b;
          count_q = '0;
          crc_q   = crc_shift_in(crc_q, b);
          phase_q = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          idx     = count_q;
          crc_q   = crc_shift_in(crc_q, b);
          count_q = count_q + 8'd1;
          if (count_q >= len_q) begin
            phase_q = PH_CHECK;
          end
          add_event(frame_event(K_PAYLOAD, b, idx));
        end
        PH_CHECK: begin
          add_event(frame_event((crc_q == b) ? K_OK : K_BAD, b, count_q));
          clear_frame();
        end
        default: begin
          clear_frame();
          if (b == SYNC_FIRST) begin
            phase_q = PH_HUNT2;
          end
        end
      endcase
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (frame_events_q.size() == 0) begin
      $error("unexpected result item: kind %0d data 0x%02h", got.kind, got.data_byte);
      mismatch_count++;
    end else begin
      want = frame_events_q.pop_front();
      check_field("kind", {6'b0, want.kind}, {6'b0, got.kind});
      check_field("func_code", want.func_code, got.func_code);
      check_field("frame_length", want.frame_length, got.frame_length);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("byte_index", want.byte_index, got.byte_index);
      check_field("computed_crc", want.computed_crc, got.computed_crc);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      frame_events_q.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        check_result(out_item);
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        parse_rx_item(in_item);
      end
    end
    events_left <= frame_events_q.size();
  end

endmodule

>>> sim/crc8_framed_packet_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_core_tb: testbench top for the crc-8 frame receiver
// Feeds short directed frames, then random frames (good, bad checksum, cut by
// timeout) mixed with line noise, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module crc8_framed_packet_receiver_core_tb;

  import crc8fpr_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASE_ITEMS    = 330;
  localparam int HOLD_OFF_CYCLES = 250;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int        stall_pct = 0;
  logic      hold_req  = 1'b0;
  logic      long_hold = 1'b0;
  int        cycle_count = 0;
  int        mismatch_total;
  int        events_left;
  in_item_t  rx_stream_q[$];

  always #6 clk = ~clk;

  crc8_framed_packet_receiver_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  crc8fpr_frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .mismatch_count (mismatch_total),
    .events_left    (events_left)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold-off so the block fills up and stalls its input
  initial begin
    wait (hold_req);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  function automatic in_item_t byte_item(input logic [7:0] b);
    in_item_t it;
    it.rx_byte         = b;
    it.timeout_expired = 1'b0;
    return it;
  endfunction

  function automatic in_item_t timeout_item();
    in_item_t it;
    it.rx_byte         = 8'($urandom);
    it.timeout_expired = 1'b1;
    return it;
  endfunction

  function automatic void add_rx(input in_item_t it);
    rx_stream_q.insert(rx_stream_q.size(), it);
  endfunction

  // fill < 0 gives random payload; cut > 0 aborts with a timeout after that many bytes
  function automatic int push_frame(input logic [7:0] func, input logic [7:0] len,
                                    input int fill, input bit corrupt, input int cut);
    logic [7:0] frame_bytes[$];
    logic [7:0] crc;
    logic [7:0] b;
    frame_bytes.insert(frame_bytes.size(), SYNC_FIRST);
    frame_bytes.insert(frame_bytes.size(), SYNC_SECOND);
    frame_bytes.insert(frame_bytes.size(), func);
    frame_bytes.insert(frame_bytes.size(), len);
    crc = crc8_byte(crc8_byte(CRC_INIT, func), len);
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      frame_bytes.insert(frame_bytes.size(), b);
      crc = crc8_byte(crc, b);
    end
    if (corrupt) begin
      crc = crc ^ (8'h01 << $urandom_range(7));
    end
    frame_bytes.insert(frame_bytes.size(), crc);
    if (cut > 0) begin
      frame_bytes = frame_bytes[0:cut-1];
    end
    foreach (frame_bytes[i]) begin
      add_rx(byte_item(frame_bytes[i]));
    end
    if (cut > 0) begin
      add_rx(timeout_item());
    end
    return frame_bytes.size() + ((cut > 0) ? 1 : 0);
  endfunction

  function automatic void push_noise();
    logic [7:0] b;
    case ($urandom_range(2))
      0: begin
        b = 8'($urandom);
        if (b == SYNC_FIRST) begin
          b = 8'h00;
        end
        add_rx(byte_item(b));
      end
      1: begin
        add_rx(timeout_item());
      end
      default: begin
        // first sync byte followed by a wrong second one
        b = 8'($urandom);
        if (b == SYNC_SECOND) begin
          b = SYNC_FIRST;
        end
        add_rx(byte_item(SYNC_FIRST));
        add_rx(byte_item(b));
      end
    endcase
  endfunction

  function automatic void build_random_frames(input int target, input bit with_longest);
    int added;
    int r;
    int len;
    int cut;
    bit corrupt;
    added = 0;
    if (with_longest) begin
      added += push_frame(8'($urandom), 8'd255, -1, 1'b0, 0);
    end
    while (added < target) begin
      if ($urandom_range(99) < 20) begin
        push_noise();
      end
      r = $urandom_range(99);
      if (r < 85) begin
        len = $urandom_range(8);
      end else if (r < 98) begin
        len = $urandom_range(40, 9);
      end else begin
        len = $urandom_range(254, 100);
      end
      r       = $urandom_range(99);
      corrupt = (r >= 75 && r < 88);
      cut     = (r >= 88) ? $urandom_range(len + 4, 1) : 0;
      added += push_frame(8'($urandom), 8'(len), -1, corrupt, cut);
    end
  endfunction

  task automatic drive_items(input int idle_pct);
    while (rx_stream_q.size() > 0) begin
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= rx_stream_q.pop_front();
      @(posedge clk);
      while (in_stall !== 1'b0) begin
        @(posedge clk);
      end
    end
  endtask

  initial begin
    int added;
    int idle_pct;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // timeout with no frame in progress, then a second sync that is not rechecked
    add_rx(timeout_item());
    add_rx(byte_item(SYNC_FIRST));
    add_rx(byte_item(SYNC_FIRST));
    add_rx(byte_item(SYNC_SECOND));
    added = push_frame(8'hFF, 8'd0, -1, 1'b0, 0);
    added = push_frame(8'h00, 8'd1, 8'h00, 1'b0, 0);
    added = push_frame(8'h5A, 8'd1, 8'hFF, 1'b1, 0);
    added = push_frame(8'h3C, 8'd2, -1, 1'b0, 5);
    drive_items(0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req  = 1'b1;
        end
        1: begin
          idle_pct  = 84;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 84;
        end
        default: begin
          idle_pct  = 33;
          stall_pct = 33;
        end
      endcase
      build_random_frames(PHASE_ITEMS, p == 0);
      drive_items(idle_pct);
    end

    @(negedge clk);
    in_valid  <= 1'b0;
    stall_pct = 0;
    wait (events_left == 0);
    repeat (20) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
